// ===== rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, constants, sector codes and the stage payload type.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int ColorBits   = 8;
  localparam int HueFracBits = 6;
  localparam int HueW        = 9 + HueFracBits;
  localparam int FracW       = 6 + HueFracBits;
  localparam int ProdW       = 2 * ColorBits;
  localparam int MixW        = ColorBits + FracW;
  localparam int DivShift    = HueFracBits + 2;
  localparam int YW          = MixW - DivShift;
  localparam int RecipShift  = ColorBits + 12;
  localparam int RecipW      = RecipShift - 3;
  localparam int Recip15     = ((1 << RecipShift) + 14) / 15;
  localparam int SectorSpan  = 60 << HueFracBits;
  localparam int FullTurn    = 360 << HueFracBits;
  localparam int SectorCount = 6;

  typedef enum logic [2:0] {
    SectorRy = 3'd0,
    SectorYg = 3'd1,
    SectorGc = 3'd2,
    SectorCb = 3'd3,
    SectorBm = 3'd4,
    SectorMr = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e              sector;
    logic [FracW-1:0]     frac_sel;
    logic [ColorBits-1:0] chroma;
    logic [ColorBits-1:0] val;
  } hsvrgb_chroma_t;

endpackage

// ===== rtl/hsvrgb_front.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Two stages: hue wrap and sector split with the v*s product, then chroma
// by division by the full-scale code and selection of the sector offset.
// ----------------------------------------------------------------------------
module hsvrgb_front import hsvrgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HueW-1:0]      hue_i,
  input  logic [ColorBits-1:0] saturation_i,
  input  logic [ColorBits-1:0] brightness_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hsvrgb_chroma_t       out_data_o
);

  logic                 s1_v_q;
  sector_e              s1_sector_q, s1_sector_d;
  logic [FracW-1:0]     s1_frac_q, s1_frac_d;
  logic [ProdW-1:0]     s1_prod_q;
  logic [ColorBits-1:0] s1_val_q;

  logic                 s2_v_q;
  hsvrgb_chroma_t       s2_data_q, s2_data_d;
  logic                 s2_ready;

  assign s2_ready   = !s2_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || s2_ready;

  always_comb begin
    logic [HueW-1:0] hw;
    logic [HueW-1:0] base;
    logic [2:0]      cnt;
    hw = (hue_i >= HueW'(FullTurn)) ? hue_i - HueW'(FullTurn) : hue_i;
    cnt = 3'd0;
    for (int k = 1; k < SectorCount; k++) begin
      cnt = cnt + 3'(hw >= HueW'(k * SectorSpan));
    end
    base = HueW'(cnt) * HueW'(SectorSpan);
    s1_sector_d = sector_e'(cnt);
    s1_frac_d   = FracW'(hw - base);
  end

  always_comb begin
    logic [ProdW:0] sum;
    sum = {1'b0, s1_prod_q} + (ProdW + 1)'(s1_prod_q >> ColorBits) + (ProdW + 1)'(1);
    s2_data_d.chroma   = sum[ColorBits +: ColorBits];
    s2_data_d.sector   = s1_sector_q;
    s2_data_d.val      = s1_val_q;
    s2_data_d.frac_sel = s1_sector_q[0] ? FracW'(SectorSpan) - s1_frac_q : s1_frac_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sector_q <= s1_sector_d;
      s1_frac_q   <= s1_frac_d;
      s1_prod_q   <= ProdW'(brightness_i) * ProdW'(saturation_i);
      s1_val_q    <= brightness_i;
    end
    if (s1_v_q && s2_ready) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_data_o  = s2_data_q;

endmodule

// ===== rtl/hsvrgb_back.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Three stages: chroma times offset, division by the sector span through a
// reciprocal multiply, then the six-way sector mux plus the m offset.
// ----------------------------------------------------------------------------
module hsvrgb_back import hsvrgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hsvrgb_chroma_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ColorBits-1:0] red_o,
  output logic [ColorBits-1:0] green_o,
  output logic [ColorBits-1:0] blue_o
);

  logic                 s3_v_q, s4_v_q, s5_v_q;
  logic                 s4_ready, s5_ready;

  logic [MixW-1:0]      s3_mix_q;
  logic [ColorBits-1:0] s3_c_q, s3_m_q;
  sector_e              s3_sector_q;

  logic [ColorBits-1:0] s4_x_q, s4_x_d, s4_c_q, s4_m_q;
  sector_e              s4_sector_q;

  logic [ColorBits-1:0] r_d, g_d, b_d;
  logic [ColorBits-1:0] r_q, g_q, b_q;

  assign s5_ready   = !s5_v_q || out_ready_i;
  assign s4_ready   = !s4_v_q || s5_ready;
  assign in_ready_o = !s3_v_q || s4_ready;

  always_comb begin
    logic [YW-1:0]        y;
    logic [YW+RecipW-1:0] q;
    y      = s3_mix_q[DivShift +: YW];
    q      = (YW + RecipW)'(y) * (YW + RecipW)'(Recip15);
    s4_x_d = q[RecipShift +: ColorBits];
  end

  always_comb begin
    logic [ColorBits-1:0] r, g, b;
    unique case (s4_sector_q)
      SectorRy: begin r = s4_c_q;    g = s4_x_q;    b = '0;     end
      SectorYg: begin r = s4_x_q;    g = s4_c_q;    b = '0;     end
      SectorGc: begin r = '0;        g = s4_c_q;    b = s4_x_q; end
      SectorCb: begin r = '0;        g = s4_x_q;    b = s4_c_q; end
      SectorBm: begin r = s4_x_q;    g = '0;        b = s4_c_q; end
      default:  begin r = s4_c_q;    g = '0;        b = s4_x_q; end
    endcase
    r_d = r + s4_m_q;
    g_d = g + s4_m_q;
    b_d = b + s4_m_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (in_ready_o) s3_v_q <= in_valid_i;
      if (s4_ready) s4_v_q <= s3_v_q;
      if (s5_ready) s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s3_mix_q    <= MixW'(in_data_i.chroma) * MixW'(in_data_i.frac_sel);
      s3_c_q      <= in_data_i.chroma;
      s3_m_q      <= in_data_i.val - in_data_i.chroma;
      s3_sector_q <= in_data_i.sector;
    end
    if (s3_v_q && s4_ready) begin
      s4_x_q      <= s4_x_d;
      s4_c_q      <= s3_c_q;
      s4_m_q      <= s3_m_q;
      s4_sector_q <= s3_sector_q;
    end
    if (s4_v_q && s5_ready) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign out_valid_o = s5_v_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;

endmodule

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one HSV pixel per item to 8-bit RGB through a five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o   | hue_i, saturation_i, brightness_i
//  out     | output    | out_valid_o / out_ready_i | red_o, green_o, blue_o
//
//  One item per cycle while the output is not stalled, through the five register stages
//  (sector split, chroma, offset multiply, reciprocal multiply, sector mux).
//  Reset clears only the stage valid bits; data registers load on advance.
//  Each stage advances when empty or when the next stage takes its item, so a
//  stall at the output backs up stage by stage and empty stages still fill.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HueW-1:0]      hue_i,
  input  logic [ColorBits-1:0] saturation_i,
  input  logic [ColorBits-1:0] brightness_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ColorBits-1:0] red_o,
  output logic [ColorBits-1:0] green_o,
  output logic [ColorBits-1:0] blue_o
);

  logic           mid_valid;
  logic           mid_ready;
  hsvrgb_chroma_t mid_data;

  hsvrgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (mid_valid),
    .out_ready_i  (mid_ready),
    .out_data_o   (mid_data)
  );

  hsvrgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

// ===== rtl/hsvrgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker import hsvrgb_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ColorBits-1:0] red_o,
  input logic [ColorBits-1:0] green_o,
  input logic [ColorBits-1:0] blue_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped during stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output item changed during stall");

  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while output side can advance");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("item did not reach output after five free cycles");

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams directed and random HSV pixels through the converter, with random
// gaps on the input, random and long stalls on the output, and checks each
// RGB result against an in-order prediction computed at input acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import hsvrgb_pkg::*;;

  localparam int ColorMax  = (1 << ColorBits) - 1;
  localparam int HueMax    = (1 << HueW) - 1;
  localparam int RandCount = 930;
  localparam int CycleCap  = 200000;
  localparam int LongHold  = 48;
  localparam int TailWait  = 20;

  typedef struct {
    logic [HueW-1:0]      hue;
    logic [ColorBits-1:0] sat;
    logic [ColorBits-1:0] val;
    int unsigned          gap;
    bit                   drain;
  } pixel_t;

  typedef struct {
    logic [ColorBits-1:0] red;
    logic [ColorBits-1:0] green;
    logic [ColorBits-1:0] blue;
  } rgb_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [HueW-1:0]      hue_i        = '0;
  logic [ColorBits-1:0] saturation_i = '0;
  logic [ColorBits-1:0] brightness_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [ColorBits-1:0] red_o;
  logic [ColorBits-1:0] green_o;
  logic [ColorBits-1:0] blue_o;

  pixel_t      pixel_q[$];
  rgb_t        rgb_expect_q[$];
  rgb_t        want;
  int unsigned pixels_queued = 0;
  int unsigned results_seen  = 0;
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle     = 0;
  int unsigned rcv_stall     = 0;
  int unsigned long_hold     = 0;
  logic        in_taken      = 1'b0;
  logic        out_taken     = 1'b0;

  hsv_to_rgb_converter_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic rgb_t convert_hsv(logic [HueW-1:0] hue, logic [ColorBits-1:0] sat,
                                       logic [ColorBits-1:0] val);
    int unsigned h, s, v, frac, sec_idx, chroma, x, m, r, g, b;
    rgb_t px;
    h       = 32'(hue);
    s       = 32'(sat);
    v       = 32'(val);
    h       = h % FullTurn;
    sec_idx = h / SectorSpan;
    frac    = h % SectorSpan;
    chroma  = (v * s) / ColorMax;
    if (sec_idx % 2 == 0) begin
      x = (chroma * frac) / SectorSpan;
    end else begin
      x = (chroma * (SectorSpan - frac)) / SectorSpan;
    end
    case (sector_e'(sec_idx))
      SectorRy: begin r = chroma; g = x;      b = 0;      end
      SectorYg: begin r = x;      g = chroma; b = 0;      end
      SectorGc: begin r = 0;      g = chroma; b = x;      end
      SectorCb: begin r = 0;      g = x;      b = chroma; end
      SectorBm: begin r = x;      g = 0;      b = chroma; end
      default:  begin r = chroma; g = 0;      b = x;      end
    endcase
    m        = v - chroma;
    px.red   = ColorBits'(r + m);
    px.green = ColorBits'(g + m);
    px.blue  = ColorBits'(b + m);
    return px;
  endfunction

  function automatic int unsigned draw_wait(int unsigned style);
    case (style)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic [ColorBits-1:0] pick_level();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? ColorBits'(ColorMax) : '0;
    end
    return ColorBits'($urandom_range(0, ColorMax));
  endfunction

  function automatic logic [HueW-1:0] pick_hue();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return HueW'($urandom_range(FullTurn, HueMax));
    end else if (pick < 3) begin
      return HueW'($urandom_range(0, 5) * SectorSpan + $urandom_range(0, 2));
    end
    return HueW'($urandom_range(0, FullTurn - 1));
  endfunction

  task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val, bit drain);
    pixel_t px;
    px.hue   = HueW'(hue);
    px.sat   = ColorBits'(sat);
    px.val   = ColorBits'(val);
    px.gap   = draw_wait((pixels_queued / 50) % 3);
    px.drain = drain;
    pixel_q.push_back(px);
    pixels_queued++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= in_valid_i && in_ready_o;
    out_taken <= out_valid_o && out_ready_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      rgb_expect_q.push_back(convert_hsv(hue_i, saturation_i, brightness_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (rgb_expect_q.size() == 0) begin
        $display("%0t: unexpected item r=%0d g=%0d b=%0d", $time, red_o, green_o, blue_o);
        err_cnt++;
      end else begin
        want = rgb_expect_q.pop_front();
        if (red_o !== want.red) begin
          $display("%0t: red expected %0d, got %0d", $time, want.red, red_o);
          err_cnt++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green expected %0d, got %0d", $time, want.green, green_o);
          err_cnt++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue expected %0d, got %0d", $time, want.blue, blue_o);
          err_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_taken) begin
        void'(pixel_q.pop_front());
      end
      if (in_valid_i && !in_taken) begin
        // hold until accepted
      end else if (pixel_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pixel_q[0].drain && rgb_expect_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (send_idle < pixel_q[0].gap) begin
        send_idle++;
        in_valid_i <= 1'b0;
      end else begin
        send_idle = 0;
        in_valid_i   <= 1'b1;
        hue_i        <= pixel_q[0].hue;
        saturation_i <= pixel_q[0].sat;
        brightness_i <= pixel_q[0].val;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        rcv_stall = draw_wait((results_seen / 64) % 3);
        if (results_seen == 300 || results_seen == 750) begin
          long_hold = LongHold;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready_i <= 1'b0;
      end else if (rcv_stall > 0) begin
        rcv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleCap) @(negedge clk_i);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    add_pixel(0, 255, 255, 1'b1);
    for (int k = 1; k < SectorCount; k++) begin
      add_pixel(k * SectorSpan, 255, 255, 1'b0);
    end
    add_pixel(SectorSpan - 1, 255, 255, 1'b0);
    add_pixel(FullTurn - 1, 255, 255, 1'b0);
    add_pixel(FullTurn, 255, 255, 1'b0);
    add_pixel(24000, 200, 180, 1'b0);
    add_pixel(HueMax, 255, 255, 1'b0);
    add_pixel(5000, 0, 200, 1'b0);
    add_pixel(10000, 255, 0, 1'b0);
    add_pixel(HueMax, 0, 0, 1'b0);
    add_pixel(3 * SectorSpan, 1, 1, 1'b0);
    add_pixel(7000, 128, 255, 1'b0);
    add_pixel(15000, 255, 128, 1'b0);
    add_pixel(5 * SectorSpan + 1234, 170, 85, 1'b0);
    add_pixel(16384, 85, 170, 1'b0);
    add_pixel(SectorSpan + 1, 255, 255, 1'b0);
    add_pixel(2 * SectorSpan - 1, 254, 253, 1'b0);
    for (int i = 0; i < RandCount; i++) begin
      add_pixel(pick_hue(), pick_level(), pick_level(), i == 0 || pixels_queued % 200 == 0);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || rgb_expect_q.size() != 0) @(negedge clk_i);
    repeat (TailWait) @(negedge clk_i);
    if (err_cnt == 0 && rgb_expect_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
